>>> rtl/pmu_pkg.sv
// Package for the polynomial multiply unit: coefficient and accumulator
// types, fixed widths, and the control bundle that steers the cell chain.
// No dependencies.
package pmu_pkg;

  localparam int COEFF_W = 16;
  localparam int PROD_W  = 2 * COEFF_W;
  localparam int ACC_W   = 36;

  typedef logic signed [COEFF_W-1:0] coeff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

  // Control broadcast to every cell of the chain in a cycle.
  typedef struct packed {
    logic clear;  // empty the store and the partial sums
    logic mac;    // take the right neighbor's multiply-accumulate sum
    logic shift;  // take the right neighbor's partial sum (flush)
  } cell_ctrl_t;

endpackage

>>> rtl/pmu_cell.sv
// One tap of the transposed convolution chain: holds one coefficient of the
// loaded polynomial and one partial sum, and hands sums to its left neighbor.
// Depends on pmu_pkg.
module pmu_cell (
  input  logic                clk,
  input  pmu_pkg::cell_ctrl_t ctrl,
  input  logic                load_sel,
  input  pmu_pkg::coeff_t     coeff,
  input  pmu_pkg::acc_t       mac_in,
  input  pmu_pkg::acc_t       shift_in,
  output pmu_pkg::acc_t       mac_out,
  output pmu_pkg::acc_t       psum_out
);

  pmu_pkg::coeff_t b_r;
  pmu_pkg::coeff_t b_nxt;
  pmu_pkg::acc_t   psum_r;
  pmu_pkg::acc_t   psum_nxt;
  pmu_pkg::prod_t  prod;

  assign prod     = coeff * b_r;
  assign mac_out  = psum_r + {{(pmu_pkg::ACC_W - pmu_pkg::PROD_W){prod[pmu_pkg::PROD_W-1]}}, prod};
  assign psum_out = psum_r;

  always_comb begin
    b_nxt    = b_r;
    psum_nxt = psum_r;
    if (ctrl.clear) begin
      b_nxt    = load_sel ? coeff : '0;
      psum_nxt = '0;
    end else begin
      if (load_sel) begin
        b_nxt = coeff;
      end
      if (ctrl.mac) begin
        psum_nxt = mac_in;
      end else if (ctrl.shift) begin
        psum_nxt = shift_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    b_r    <= b_nxt;
    psum_r <= psum_nxt;
  end

endmodule

>>> rtl/polynomial_multiply_unit.sv
// Top level of the polynomial multiply unit: request handshakes, load and
// flush control, and the chain of pmu_cell taps. Depends on pmu_pkg, pmu_cell.
//
// This unit multiplies two polynomials with signed Q8.8 coefficients and
// returns the product coefficients in signed Q20.16, 36 bits, wrapped with no
// saturation. First send the second polynomial as requests with in_func = 0,
// lowest order first, in_last on its highest-order coefficient; up to
// MAX_TERMS coefficients are kept and any beyond are ignored. Then stream the
// first polynomial with in_func = 1, lowest order first. Each streamed request
// returns one product coefficient in the cycle after it is accepted, since all
// MAX_TERMS cells multiply and accumulate in parallel, so the stream runs at
// one request per cycle. A streamed request with in_last set also releases
// the remaining loaded_count-1 coefficients, one per cycle from the cell
// chain shifting toward the output; the input stalls during that flush, and
// out_product_last flags the final coefficient. The loaded polynomial stays
// in the cells for further products. A load after a closed load or after any
// stream starts the store over and drops an unfinished product. With nothing
// loaded, streamed requests produce no output. The input and the flush also
// stall while a result waits in the output register and the output is stalled.
module polynomial_multiply_unit #(
  parameter int MAX_TERMS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_func,
  input  logic signed [15:0]    in_coeff,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [35:0]    out_product_coeff,
  output logic                  out_product_last
);

  localparam int CNT_W = $clog2(MAX_TERMS + 1);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_FLUSH = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] loaded_count_r, loaded_count_nxt;
  logic             loading_open_r, loading_open_nxt;
  logic [CNT_W-1:0] flush_cnt_r, flush_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  pmu_pkg::acc_t    out_coeff_r, out_coeff_nxt;
  logic             out_last_r, out_last_nxt;

  logic             accept;
  logic             load_acc;
  logic             strm_acc;
  logic             strm_go;
  logic             out_free;
  logic             flush_step;
  logic [CNT_W-1:0] wr_idx;
  logic             wr_en;
  pmu_pkg::cell_ctrl_t ctrl;

  // Chain links: index k is driven by cell k; index MAX_TERMS is the zero
  // fed into the rightmost cell.
  pmu_pkg::acc_t mac_link  [MAX_TERMS+1];
  pmu_pkg::acc_t psum_link [MAX_TERMS+1];

  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = (state_r == ST_FLUSH) || (out_valid_r && out_stall);
  assign accept     = in_valid && !in_stall;
  assign load_acc   = accept && !in_func;
  assign strm_acc   = accept && in_func;
  assign strm_go    = strm_acc && (loaded_count_r != '0);
  assign flush_step = (state_r == ST_FLUSH) && out_free;

  // A load that opens a new polynomial writes at the bottom of a cleared store.
  assign wr_idx = loading_open_r ? loaded_count_r : '0;
  assign wr_en  = load_acc && (wr_idx < CNT_W'(MAX_TERMS));

  assign ctrl.clear = load_acc && !loading_open_r;
  assign ctrl.mac   = strm_go;
  assign ctrl.shift = flush_step;

  assign mac_link[MAX_TERMS]  = '0;
  assign psum_link[MAX_TERMS] = '0;

  for (genvar k = 0; k < MAX_TERMS; k++) begin : g_cell
    pmu_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .load_sel (wr_en && (wr_idx == CNT_W'(k))),
      .coeff    (in_coeff),
      .mac_in   (mac_link[k+1]),
      .shift_in (psum_link[k+1]),
      .mac_out  (mac_link[k]),
      .psum_out (psum_link[k])
    );
  end

  always_comb begin
    state_nxt        = state_r;
    loaded_count_nxt = loaded_count_r;
    loading_open_nxt = loading_open_r;
    flush_cnt_nxt    = flush_cnt_r;
    out_valid_nxt    = out_valid_r;
    out_coeff_nxt    = out_coeff_r;
    out_last_nxt     = out_last_r;

    if (load_acc) begin
      loaded_count_nxt = wr_en ? (wr_idx + CNT_W'(1)) : wr_idx;
      loading_open_nxt = !in_last;
    end else if (strm_acc) begin
      loading_open_nxt = 1'b0;
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (strm_go) begin
      // Cell 0's sum is the next product coefficient.
      out_valid_nxt = 1'b1;
      out_coeff_nxt = mac_link[0];
      out_last_nxt  = in_last && (loaded_count_r == CNT_W'(1));
      if (in_last && (loaded_count_r != CNT_W'(1))) begin
        state_nxt     = ST_FLUSH;
        flush_cnt_nxt = loaded_count_r - CNT_W'(1);
      end
    end else if (flush_step) begin
      // The chain shifts left; zeros enter at the right so it ends cleared.
      out_valid_nxt = 1'b1;
      out_coeff_nxt = psum_link[0];
      out_last_nxt  = (flush_cnt_r == CNT_W'(1));
      flush_cnt_nxt = flush_cnt_r - CNT_W'(1);
      if (flush_cnt_r == CNT_W'(1)) begin
        state_nxt = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      loaded_count_r <= '0;
      loading_open_r <= 1'b0;
      flush_cnt_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      loaded_count_r <= loaded_count_nxt;
      loading_open_r <= loading_open_nxt;
      flush_cnt_r    <= flush_cnt_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_coeff_r <= out_coeff_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_product_coeff = out_coeff_r;
  assign out_product_last  = out_last_r;

  // The store never counts past its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_count_r <= CNT_W'(MAX_TERMS))
    else $error("loaded count exceeds store capacity");

  // A flush always has coefficients left and never runs longer than the store.
  a_flush_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) |-> ((flush_cnt_r != '0) && (flush_cnt_r < loaded_count_r)))
    else $error("flush count out of range");

  // A closing stream request with more than one loaded term starts a flush.
  a_flush_start: assert property (@(posedge clk) disable iff (!rst_n)
    (strm_go && in_last && (loaded_count_r != CNT_W'(1))) |=> (state_r == ST_FLUSH))
    else $error("flush did not start after closing stream request");

  // The last flush step delivers a result, and it carries the flag.
  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    (flush_step && (flush_cnt_r == CNT_W'(1))) |=> (out_valid && out_product_last))
    else $error("final flush result not flagged");

endmodule
